FILE: rtl/core/mpq_pkg.sv
// shared types and constants for the sorted max priority queue
`default_nettype none

package mpq_pkg;

    localparam int VALUE_W       = 32;
    localparam int ENTRY_COUNT_W = 7;

    typedef enum logic
    {
        MPQ_OP_ENQ = 1'b0,
        MPQ_OP_DEQ = 1'b1
    } mpq_op_t;

    // what one cell shows its neighbors
    typedef struct packed
    {
        logic                      valid;
        logic signed [VALUE_W-1:0] data;
        logic                      lt;      // valid and data below the broadcast value
    } mpq_link_t;

    // broadcast to every cell in the chain
    typedef struct packed
    {
        logic                      enq;
        logic                      deq;
        logic signed [VALUE_W-1:0] value;
    } mpq_cmd_t;

endpackage : mpq_pkg

`default_nettype wire

FILE: rtl/core/mpq_if.sv
// request and response stream interfaces of the priority queue
`default_nettype none

interface mpq_req_if;
    logic                               valid;
    logic                               ready;
    logic                               mode;
    logic signed [mpq_pkg::VALUE_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface : mpq_req_if

interface mpq_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [mpq_pkg::VALUE_W-1:0]      max_value;
    logic                                    max_valid;
    logic                                    empty_error;
    logic                                    full_drop;
    logic [mpq_pkg::ENTRY_COUNT_W-1:0]       entry_count;
    logic                                    is_empty;

    modport source (output valid, output max_value, output max_valid, output empty_error,
                    output full_drop, output entry_count, output is_empty, input ready);
    modport sink   (input valid, input max_value, input max_valid, input empty_error,
                    input full_drop, input entry_count, input is_empty, output ready);
endinterface : mpq_rsp_if

`default_nettype wire

FILE: rtl/core/mpq_cell.sv
// one compare-and-shift cell of the sorted chain
`default_nettype none

module mpq_cell
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  mpq_pkg::mpq_cmd_t   cmd,
    input  mpq_pkg::mpq_link_t  left,
    input  mpq_pkg::mpq_link_t  right,
    output mpq_pkg::mpq_link_t  self
);
    import mpq_pkg::*;

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [VALUE_W-1:0] data_reg;
    logic signed [VALUE_W-1:0] data_next;
    logic                      lt;

    assign lt = valid_reg && (data_reg < cmd.value);

    always_comb
    begin
        priority if (cmd.enq)
        begin
            priority if (left.lt)
            begin
                // insertion point is further left, move over by one
                valid_next = left.valid;
                data_next  = left.data;
            end
            else if (left.valid && (lt || !valid_reg))
            begin
                // new value lands here, behind any equal values
                valid_next = 1'b1;
                data_next  = cmd.value;
            end
            else
            begin
                valid_next = valid_reg;
                data_next  = data_reg;
            end
        end
        else if (cmd.deq)
        begin
            valid_next = right.valid;
            data_next  = right.data;
        end
        else
        begin
            valid_next = valid_reg;
            data_next  = data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign self.valid = valid_reg;
    assign self.data  = data_reg;
    assign self.lt    = lt;

endmodule : mpq_cell

`default_nettype wire

FILE: rtl/core/max_priority_queue_unit.sv
// top level of the sorted max priority queue built as a chain of cells
//
//  channel | dir | carries
//  --------+-----+----------------------------------------------------------
//  req     | in  | mode (enqueue / dequeue), value
//  rsp     | out | max_value, max_valid, empty_error, full_drop, entry_count,
//          |     | is_empty
//
// one request per cycle while rsp is not stalled: every cell compares against the
// broadcast value and shifts in the same cycle, and each response is a registered beat
// the response register frees up when its beat is taken, req.ready follows it
// reset empties the chain at once by clearing the cell occupancy bits
// a stalled rsp holds its beat and stalls req, no item is lost or repeated
`default_nettype none

module max_priority_queue_unit
#(
    parameter int CAPACITY = 64
)
(
    input  wire          clk,
    input  wire          rst_n,
    mpq_req_if.sink      req,
    mpq_rsp_if.source    rsp
);
    import mpq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    localparam mpq_link_t HEAD = '{valid: 1'b1, data: '0, lt: 1'b0};
    localparam mpq_link_t TAIL = '{valid: 1'b0, data: '0, lt: 1'b0};

    mpq_link_t               cell_q [CAPACITY];
    logic [CAPACITY-1:0]     occ;
    mpq_cmd_t                cmd;

    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic                    req_accept;
    logic                    is_deq;
    logic                    full;
    logic                    empty;

    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    logic signed [VALUE_W-1:0] max_value_reg;
    logic                    max_valid_reg;
    logic                    empty_error_reg;
    logic                    full_drop_reg;
    logic [ENTRY_COUNT_W-1:0] entry_count_reg;
    logic                    is_empty_reg;
    logic [CW+ENTRY_COUNT_W-1:0] count_wide;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            mpq_link_t left_in;
            mpq_link_t right_in;
            if (gi == 0)
            begin : g_head
                assign left_in = HEAD;
            end
            else
            begin : g_mid_l
                assign left_in = cell_q[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_in = TAIL;
            end
            else
            begin : g_mid_r
                assign right_in = cell_q[gi+1];
            end
            mpq_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cmd),
                .left  (left_in),
                .right (right_in),
                .self  (cell_q[gi])
            );
            assign occ[gi] = cell_q[gi].valid;
        end
    endgenerate

    assign req.ready  = !rsp_valid_reg || rsp.ready;
    assign req_accept = req.valid && req.ready;
    assign is_deq     = (mpq_op_t'(req.mode) == MPQ_OP_DEQ);
    assign full       = (count_reg == CW'(CAPACITY));
    assign empty      = (count_reg == '0);

    assign cmd.enq   = req_accept && !is_deq && !full;
    assign cmd.deq   = req_accept && is_deq && !empty;
    assign cmd.value = req.value;

    always_comb
    begin
        priority if (cmd.enq)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.deq)
        begin
            count_next = count_reg - CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_comb
    begin
        priority if (req_accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign count_wide = {{ENTRY_COUNT_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            max_value_reg   <= cmd.deq ? cell_q[0].data : '0;
            max_valid_reg   <= cmd.deq;
            empty_error_reg <= is_deq && empty;
            full_drop_reg   <= !is_deq && full;
            entry_count_reg <= count_wide[ENTRY_COUNT_W-1:0];
            is_empty_reg    <= (count_next == '0);
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.max_value   = max_value_reg;
    assign rsp.max_valid   = max_valid_reg;
    assign rsp.empty_error = empty_error_reg;
    assign rsp.full_drop   = full_drop_reg;
    assign rsp.entry_count = entry_count_reg;
    assign rsp.is_empty    = is_empty_reg;

    // occupancy of the chain stays a packed run matching the count
    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ) == int'(count_reg))
        else $error("cell occupancy disagrees with count");

    a_occ_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((occ & (occ + CAPACITY'(1))) == '0))
        else $error("occupied cells are not a packed run from the head");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("count above capacity");

    a_deq_beat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.deq |=> rsp.valid && rsp.max_valid && !rsp.empty_error)
        else $error("dequeue of a held value gave no valid maximum");

    a_drop_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && !is_deq && full) |=> (count_reg == $past(count_reg)) && rsp.full_drop)
        else $error("dropped enqueue changed the queue");

endmodule : max_priority_queue_unit

`default_nettype wire

FILE: verif/max_priority_queue_unit_tb.sv
// self-checking testbench for the sorted max priority queue unit
`default_nettype none

module max_priority_queue_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mpq_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 16;
    localparam int RANDOM_CMDS = 1250;

    typedef struct
    {
        mpq_op_t                   op;
        logic signed [VALUE_W-1:0] value;
        bit                        wait_drain;   // hold this beat until every response is back
    } queue_cmd_t;

    typedef struct
    {
        logic signed [VALUE_W-1:0]     max_value;
        logic                          max_valid;
        logic                          empty_error;
        logic                          full_drop;
        logic [ENTRY_COUNT_W-1:0]      entry_count;
        logic                          is_empty;
    } queue_rsp_t;

    logic clk;
    logic rst_n;

    mpq_req_if req_bus ();
    mpq_rsp_if rsp_bus ();

    max_priority_queue_unit #(.CAPACITY(CAPACITY)) u_dut
    (
        .clk   (clk),
        .rsp   (rsp_bus),
        .req   (req_bus),
        .rst_n (rst_n)
    );

    queue_cmd_t                cmd_backlog[$];
    queue_rsp_t                predicted_rsp_q[$];
    logic signed [VALUE_W-1:0] model_store[$];     // descending, front is the maximum

    int  error_cnt = 0;
    int  sent_cnt  = 0;
    int  done_cnt  = 0;
    int  cycle_cnt = 0;
    bit  calm      = 1'b0;
    int  gap_left  = 0;
    int  stall_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_error(string msg);
        $display("ERROR beat %0d: %s", done_cnt, msg);
        error_cnt++;
    endtask

    task automatic check_field(string name, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
        if (got !== want)
            report_error($sformatf("%s got 0x%08h expected 0x%08h", name, got, want));
    endtask

    // updates the sorted store and returns the response this command must produce
    function automatic queue_rsp_t apply_request(mpq_op_t op, logic signed [VALUE_W-1:0] val);
        queue_rsp_t rsp;
        int         pos;
        rsp = '{max_value: '0, max_valid: 1'b0, empty_error: 1'b0, full_drop: 1'b0,
                entry_count: '0, is_empty: 1'b0};
        if (op == MPQ_OP_ENQ)
        begin
            if (model_store.size() >= CAPACITY)
                rsp.full_drop = 1'b1;
            else
            begin
                // equal values stay ahead of the newcomer
                pos = 0;
                while (pos < model_store.size() && !(model_store[pos] < val))
                    pos++;
                model_store.insert(pos, val);
            end
        end
        else
        begin
            if (model_store.size() == 0)
                rsp.empty_error = 1'b1;
            else
            begin
                rsp.max_value = model_store.pop_front();
                rsp.max_valid = 1'b1;
            end
        end
        rsp.entry_count = ENTRY_COUNT_W'(model_store.size());
        rsp.is_empty    = (model_store.size() == 0);
        return rsp;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_cmd(mpq_op_t op, logic signed [VALUE_W-1:0] val, bit wait_drain = 1'b0);
        queue_cmd_t cmd;
        cmd.op         = op;
        cmd.value      = val;
        cmd.wait_drain = wait_drain;
        cmd_backlog.push_back(cmd);
    endtask

    // cycle counter, quiet stretches and timeout
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        calm      <= ((cycle_cnt / 64) % 8 == 0);
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        queue_cmd_t cmd;
        int         landed;
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
                sent_cnt = sent_cnt + 1;
            landed = done_cnt + ((rsp_bus.valid && rsp_bus.ready) ? 1 : 0);
            if (!req_bus.valid || req_bus.ready)
            begin
                if (gap_left != 0)
                begin
                    req_bus.valid <= 1'b0;
                    gap_left = gap_left - 1;
                end
                else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].wait_drain && sent_cnt != landed))
                begin
                    cmd = cmd_backlog.pop_front();
                    req_bus.valid <= 1'b1;
                    req_bus.mode  <= cmd.op;
                    req_bus.value <= cmd.value;
                    gap_left = pick_gap();
                end
                else
                    req_bus.valid <= 1'b0;
            end
        end
    end

    // response back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left != 0)
        begin
            rsp_bus.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            rsp_bus.ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // monitor: predict on each request beat, check each response beat
    always @(posedge clk)
    begin
        queue_rsp_t want;
        if (rst_n)
        begin
            if (req_bus.valid && req_bus.ready)
                predicted_rsp_q.push_back(apply_request(mpq_op_t'(req_bus.mode), req_bus.value));
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                done_cnt <= done_cnt + 1;
                if (predicted_rsp_q.size() == 0)
                    report_error("response beat with nothing outstanding");
                else
                begin
                    want = predicted_rsp_q.pop_front();
                    check_field("max_value", rsp_bus.max_value, want.max_value);
                    check_field("max_valid", rsp_bus.max_valid, want.max_valid);
                    check_field("empty_error", rsp_bus.empty_error, want.empty_error);
                    check_field("full_drop", rsp_bus.full_drop, want.full_drop);
                    check_field("entry_count", rsp_bus.entry_count, want.entry_count);
                    check_field("is_empty", rsp_bus.is_empty, want.is_empty);
                end
            end
        end
    end

    initial
    begin
        int n;
        int len;
        int kind;
        bit pause_done;
        mpq_op_t op;

        rst_n         = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.mode  = MPQ_OP_ENQ;
        req_bus.value = '0;
        rsp_bus.ready = 1'b0;

        // directed: empty dequeue, value extremes, duplicates, drain past empty
        push_cmd(MPQ_OP_DEQ, 32'sh1234_5678);
        push_cmd(MPQ_OP_ENQ, 32'sh7fff_ffff);
        push_cmd(MPQ_OP_ENQ, 32'sh8000_0000);
        push_cmd(MPQ_OP_ENQ, 32'sh0000_0000);
        push_cmd(MPQ_OP_ENQ, -32'sd1);
        push_cmd(MPQ_OP_ENQ, 32'sd1);
        push_cmd(MPQ_OP_ENQ, 32'sd5);
        push_cmd(MPQ_OP_ENQ, 32'sd5);
        push_cmd(MPQ_OP_ENQ, 32'sd5);
        push_cmd(MPQ_OP_ENQ, 32'sh5555_5555);
        push_cmd(MPQ_OP_ENQ, 32'shaaaa_aaaa);
        for (int i = 0; i < 11; i++)
            push_cmd(MPQ_OP_DEQ, 32'shffff_ffff);

        // random: fill and drain runs push through full and empty, mixed runs in between
        n = 0;
        pause_done = 1'b0;
        while (n < RANDOM_CMDS)
        begin
            kind = $urandom_range(0, 3);
            len  = (kind < 2) ? $urandom_range(60, 75) : $urandom_range(20, 60);
            for (int i = 0; i < len; i++)
            begin
                case (kind)
                    0:       op = MPQ_OP_ENQ;
                    1:       op = MPQ_OP_DEQ;
                    default: op = mpq_op_t'($urandom_range(0, 1));
                endcase
                push_cmd(op, (kind == 3) ? 32'(int'($urandom_range(0, 7)) - 4) : pick_value(),
                         (n == 0) || (!pause_done && n >= RANDOM_CMDS / 2));
                if (n >= RANDOM_CMDS / 2)
                    pause_done = 1'b1;
                n++;
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (cmd_backlog.size() != 0 || req_bus.valid || sent_cnt != done_cnt);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (predicted_rsp_q.size() != 0)
            report_error($sformatf("%0d responses never arrived", predicted_rsp_q.size()));

        if (error_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule : max_priority_queue_unit_tb

`default_nettype wire

FILE: sim.f
rtl/core/mpq_pkg.sv
rtl/core/mpq_if.sv
rtl/core/mpq_cell.sv
rtl/core/max_priority_queue_unit.sv
verif/max_priority_queue_unit_tb.sv
